// File: src/kss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the k-sorted stream sorter.
// No dependencies; the cell and the top level import this package.
package kss_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int K_W      = 4;
    localparam int FILL_W   = $clog2(CAPACITY + 1);

    localparam logic [K_W-1:0] WINDOW_K_RESET = K_W'(3);

    typedef logic signed [DATA_W-1:0] data_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

endpackage

// File: src/kss_cell.sv
`timescale 1ns / 1ps
// One position of the sorted chain: holds a value and shifts it with its neighbors.
// Depends on kss_pkg.
module kss_cell
    import kss_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  data_t      new_value,
    input  logic       occ_self,
    input  logic       occ_left,
    input  logic       lt_left,
    input  data_t      value_left,
    input  data_t      value_right,
    output data_t      value,
    output logic       lt
);

    data_t value_reg;
    data_t value_next;

    assign value = value_reg;
    assign lt    = occ_self && (new_value < value_reg);

    always_comb begin
        value_next = value_reg;
        if (ctrl.pop) begin
            value_next = value_right;
        end else if (ctrl.insert) begin
            if (lt || (!occ_self && occ_left)) begin
                value_next = (occ_left && lt_left) ? value_left : new_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

// File: src/k_sorted_stream_sorter.sv
`timescale 1ns / 1ps
// Top level of the k-sorted stream sorter: control, fill count, output register, cell chain.
// Depends on kss_pkg and kss_cell.
//
// The sorter keeps up to min(window_k + 1, CAPACITY) values in a chain of cells kept in
// ascending order; an insert or a removal of the minimum shifts all cells of the chain at
// once. An input beat is taken only when the control is idle. A beat that finds the store
// not yet full is accepted and then inserted. A beat that finds it full is accepted, then
// moves the minimum into the output register once that register is free, and is then
// inserted. A beat marked end of stream then drains the chain at one beat per cycle while
// the output side is ready, and the final beat carries last_sorted. window_k is written
// through the configuration channel and should change only while idle.
module k_sorted_stream_sorter
    import kss_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  data_t          s_sample_value,
    input  logic           s_end_of_stream,
    output logic           m_valid,
    input  logic           m_ready,
    output data_t          m_sorted_value,
    output logic           m_last_sorted,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [K_W-1:0] cfg_window_k
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_POP   = 2'd1;
    localparam logic [1:0] ST_INS   = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [K_W-1:0]    window_k_reg;
    data_t             sample_reg;
    logic              last_reg;
    logic              m_valid_reg, m_valid_next;
    data_t             m_value_reg;
    logic              m_last_reg;

    cell_ctrl_t        ctrl;
    logic              out_free;
    logic              full;
    logic              load_out;
    logic              accept;

    data_t             cell_value [CAPACITY];
    logic              cell_lt    [CAPACITY];
    logic              occ        [CAPACITY];

    assign s_ready        = (state_reg == ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_sorted_value = m_value_reg;
    assign m_last_sorted  = m_last_reg;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign full     = (fill_reg != '0)
                      && ((32'(fill_reg) >= 32'(window_k_reg) + 32'd1)
                          || (32'(fill_reg) >= 32'(CAPACITY)));

    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        ctrl.insert = 1'b0;
        ctrl.pop    = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = full ? ST_POP : ST_INS;
                end
            end
            ST_POP: begin
                if (out_free) begin
                    ctrl.pop   = 1'b1;
                    load_out   = 1'b1;
                    fill_next  = fill_reg - FILL_W'(1);
                    state_next = ST_INS;
                end
            end
            ST_INS: begin
                if (32'(fill_reg) < 32'(CAPACITY)) begin
                    ctrl.insert = 1'b1;
                    fill_next   = fill_reg + FILL_W'(1);
                end
                state_next = last_reg ? ST_DRAIN : ST_IDLE;
            end
            ST_DRAIN: begin
                if (fill_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    ctrl.pop  = 1'b1;
                    load_out  = 1'b1;
                    fill_next = fill_reg - FILL_W'(1);
                    if (fill_reg == FILL_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            window_k_reg <= WINDOW_K_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                window_k_reg <= cfg_window_k;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_sample_value;
            last_reg   <= s_end_of_stream;
        end
        if (load_out) begin
            m_value_reg <= cell_value[0];
            m_last_reg  <= (state_reg == ST_DRAIN) && (fill_reg == FILL_W'(1));
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        data_t value_left;
        data_t value_right;
        logic  occ_left;
        logic  lt_left;

        assign occ[i] = (32'(fill_reg) > i);

        if (i == 0) begin : g_first
            assign value_left = '0;
            assign occ_left   = 1'b1;
            assign lt_left    = 1'b0;
        end else begin : g_inner
            assign value_left = cell_value[i-1];
            assign occ_left   = occ[i-1];
            assign lt_left    = cell_lt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_end
            assign value_right = '0;
        end else begin : g_mid
            assign value_right = cell_value[i+1];
        end

        kss_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .new_value   (sample_reg),
            .occ_self    (occ[i]),
            .occ_left    (occ_left),
            .lt_left     (lt_left),
            .value_left  (value_left),
            .value_right (value_right),
            .value       (cell_value[i]),
            .lt          (cell_lt[i])
        );
    end

endmodule

// File: tb/sv/k_sorted_stream_sorter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for k_sorted_stream_sorter: directed and random streams, window
// changes while idle, random stalls on both sides and one long output hold-off.
// Depends on kss_pkg and the k_sorted_stream_sorter RTL.
module k_sorted_stream_sorter_tb;
    import kss_pkg::*;

    localparam int DIRECTED_ITEMS = 25;
    localparam int RANDOM_ITEMS   = 235;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int TIMEOUT_NS     = 2_000_000;

    typedef struct packed {
        data_t value;
        logic  last;
    } sorted_beat_t;

    class sorter_scoreboard;
        data_t          held[CAPACITY];
        int unsigned    held_count;
        logic [K_W-1:0] window_k;
        sorted_beat_t   sorted_due[$];
        int unsigned    errors;

        function new();
            held_count = 0;
            window_k   = WINDOW_K_RESET;
            errors     = 0;
        endfunction

        function int unsigned pending();
            return sorted_due.size();
        endfunction

        function data_t take_min();
            data_t low_value;
            low_value = held[0];
            for (int i = 1; i < held_count; i++) begin
                held[i-1] = held[i];
            end
            held_count--;
            return low_value;
        endfunction

        function void add_due(data_t value, logic last);
            sorted_beat_t beat;
            beat.value = value;
            beat.last  = last;
            sorted_due.push_back(beat);
        endfunction

        function void note_sample(data_t value, logic eos);
            int unsigned limit;
            int unsigned pos;
            data_t       low_value;
            limit = window_k + 1;
            if (limit > CAPACITY) begin
                limit = CAPACITY;
            end
            if (held_count >= limit && held_count > 0) begin
                add_due(take_min(), 1'b0);
            end
            pos = held_count;
            while (pos > 0 && value < held[pos-1]) begin
                held[pos] = held[pos-1];
                pos--;
            end
            held[pos] = value;
            held_count++;
            if (eos) begin
                while (held_count > 0) begin
                    low_value = take_min();
                    add_due(low_value, held_count == 0);
                end
            end
        endfunction

        function void check_result(data_t value, logic last);
            sorted_beat_t want;
            if (sorted_due.size() == 0) begin
                $error("sorted_value: expected no beat, actual %0d", value);
                errors++;
                return;
            end
            want = sorted_due.pop_front();
            if (value !== want.value) begin
                $error("sorted_value: expected %0d, actual %0d", want.value, value);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_sorted: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic           aclk            = 1'b0;
    logic           aresetn         = 1'b0;
    logic           s_valid         = 1'b0;
    logic           s_ready;
    data_t          s_sample_value  = '0;
    logic           s_end_of_stream = 1'b0;
    logic           m_valid;
    logic           m_ready         = 1'b0;
    data_t          m_sorted_value;
    logic           m_last_sorted;
    logic           cfg_valid       = 1'b0;
    logic           cfg_ready;
    logic [K_W-1:0] cfg_window_k    = '0;

    sorter_scoreboard sb;
    bit               calm        = 1'b0;
    bit               open_stream = 1'b0;
    int unsigned      items_sent  = 0;
    int unsigned      hold_req    = 0;
    int unsigned      hold_done   = 0;

    k_sorted_stream_sorter u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_value  (s_sample_value),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sorted_value  (m_sorted_value),
        .m_last_sorted   (m_last_sorted),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_window_k    (cfg_window_k)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_sample(s_sample_value, s_end_of_stream);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_sorted_value, m_last_sorted);
            end
            if (cfg_valid && cfg_ready) begin
                sb.window_k = cfg_window_k;
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req != hold_done) begin
                hold_done = hold_req;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= calm || $urandom_range(99) >= 15;
        end
    end

    task automatic send_sample(input data_t value, input logic eos);
        while (!calm && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_sample_value  <= value;
        s_end_of_stream <= eos;
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
        items_sent++;
        open_stream = !eos;
    endtask

    task automatic write_window(input logic [K_W-1:0] k);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid    <= 1'b1;
        cfg_window_k <= k;
        @(posedge aclk);
        while (!(cfg_valid && cfg_ready)) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Most streams are ramps with local swaps no wider than the window; the rest are noise
    // or tightly clustered values with many duplicates.
    task automatic send_stream(input int unsigned len, input bit close, input int unsigned k);
        data_t       vals[$];
        data_t       level;
        data_t       swap_value;
        int unsigned mode;
        int unsigned j;
        mode  = $urandom_range(9);
        level = data_t'($urandom);
        for (int i = 0; i < len; i++) begin
            if (mode < 6) begin
                level = level + data_t'($urandom_range(1000));
                vals.push_back(level);
            end else if (mode < 8) begin
                vals.push_back(data_t'($urandom));
            end else begin
                vals.push_back(data_t'(int'($urandom_range(6)) - 3));
            end
        end
        if (mode < 6) begin
            for (int i = 0; i + 1 < len; i++) begin
                j = i + $urandom_range(k);
                if ($urandom_range(3) == 0 && j < len) begin
                    swap_value = vals[i];
                    vals[i]    = vals[j];
                    vals[j]    = swap_value;
                end
            end
        end
        for (int i = 0; i < len; i++) begin
            send_sample(vals[i], close && i == len - 1);
        end
    endtask

    initial begin
        int unsigned phase;
        int unsigned k;
        int unsigned streams;
        int unsigned len;
        bit          close;
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_sample(data_t'(32'h7FFF_FFFF), 1'b0);
        send_sample(data_t'(32'h8000_0000), 1'b0);
        send_sample(data_t'(0), 1'b0);
        send_sample(data_t'(-1), 1'b0);
        send_sample(data_t'(5), 1'b0);
        send_sample(data_t'(5), 1'b0);
        send_sample(data_t'(5), 1'b0);
        send_sample(data_t'(1), 1'b0);
        send_sample(data_t'(-7), 1'b1);

        send_sample(data_t'(10), 1'b0);
        send_sample(data_t'(-10), 1'b0);
        send_sample(data_t'(0), 1'b1);
        send_sample(data_t'(32'h8000_0000), 1'b1);

        write_window(4'd0);
        send_sample(data_t'(3), 1'b0);
        send_sample(data_t'(1), 1'b0);
        send_sample(data_t'(2), 1'b1);

        // The window opens wide, then shrinks and grows again while values are held.
        write_window(4'd15);
        send_sample(data_t'(100), 1'b0);
        send_sample(data_t'(-100), 1'b0);
        send_sample(data_t'(50), 1'b0);
        send_sample(data_t'(7), 1'b0);
        write_window(4'd1);
        send_sample(data_t'(8), 1'b0);
        send_sample(data_t'(-200), 1'b0);
        write_window(4'd7);
        send_sample(data_t'(9), 1'b0);
        send_sample(data_t'(9), 1'b0);
        send_sample(data_t'(1000), 1'b1);

        phase = 0;
        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            case (phase)
                0, 3:    k = 15;
                1:       k = 0;
                default: k = $urandom_range(15);
            endcase
            write_window(K_W'(k));
            calm = (phase == 2);
            if (phase == 3) begin
                hold_req++;
                send_stream(40, 1'b1, k);
            end
            streams = $urandom_range(1, 3);
            for (int s = 0; s < streams; s++) begin
                if ($urandom_range(7) == 0) begin
                    len = $urandom_range(20, 40);
                end else begin
                    len = $urandom_range(1, 2 * (k + 1) + 3);
                end
                close = (s + 1 < streams) || $urandom_range(4) != 0;
                send_stream(len, close, k);
            end
            calm = 1'b0;
            phase++;
        end
        if (open_stream) begin
            send_sample(data_t'($urandom), 1'b1);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
src/kss_pkg.sv
src/kss_cell.sv
src/k_sorted_stream_sorter.sv
tb/sv/k_sorted_stream_sorter_tb.sv
